@@ design/humidity_temp_frame_check_convert_macros.svh @@
// assertion macros shared by the frame check and convert checker
`ifndef HUMIDITY_TEMP_FRAME_CHECK_CONVERT_MACROS_SVH
`define HUMIDITY_TEMP_FRAME_CHECK_CONVERT_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define HTFCC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("htfcc same-cycle check failed");

// next-cycle implication, clocked on clk, off during reset
`define HTFCC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("htfcc next-cycle check failed");

// condition that must hold in the cycle after reset is seen
`define HTFCC_ASSERT_RST(lbl, cons) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("htfcc reset check failed");

`endif

@@ design/htfcc_pkg.sv @@
// constants and crc helper for the sensor frame check and convert block
package htfcc_pkg;

  // measurement kind codes
  localparam logic KindTemp = 1'b0;
  localparam logic KindHumi = 1'b1;

  // status bit masks on the raw word
  localparam logic [15:0] TempMask = 16'hFFFC;
  localparam logic [15:0] HumiMask = 16'hFFF0;

  // scale factors in hundredths per full scale of 2^16
  localparam int GainW = 15;
  localparam logic [GainW-1:0] TempGain = 15'd17572;
  localparam logic [GainW-1:0] HumiGain = 15'd12500;

  // product of gain and raw word
  localparam int ProdW = GainW + 16;

  // offsets in hundredths, subtracted after the floor
  localparam logic signed [15:0] TempOffset = 16'sd4685;
  localparam logic signed [15:0] HumiOffset = 16'sd600;

  // crc-8, x^8+x^5+x^4+1, msb first
  localparam logic [7:0] CrcPoly = 8'h31;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] c;
    c = crc_in ^ data;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

@@ design/humidity_temp_frame_check_convert.sv @@
// Sensor frame check and convert. Each transaction carries one three-byte frame
// (two data bytes and a checksum) plus its kind, temperature or humidity. The
// block computes the crc-8 (poly 0x31, init 0, msb first) over the data bytes,
// flags whether it matches the checksum, clears the status bits of the raw
// word and scales it to hundredths of a degree or percent, floored; a frame
// with a bad checksum reports a value of zero. Frames are independent and one
// can be taken every cycle while the output is not stalled; each result passes
// through the three register stages before it is presented: crc of the first
// byte and masking, crc of the second byte and the gain multiply, then offset
// and checksum compare into the output register. Each stage holds its item
// while the one after it is full, so stalls lose nothing.
module humidity_temp_frame_check_convert (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               kind,
  input  logic [7:0]         high_byte,
  input  logic [7:0]         low_byte,
  input  logic [7:0]         check_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               check_ok,
  output logic signed [14:0] value_hundredths,
  output logic [7:0]         computed_crc
);
  import htfcc_pkg::*;

  // stage registers
  logic                     v1, v2, v3;
  logic                     kind1, kind2;
  logic [7:0]               lo1, chk1, crc1;
  logic [15:0]              raw1;
  logic [7:0]               chk2, crc2;
  logic [ProdW-1:0]         prod2;
  logic                     ok3;
  logic signed [14:0]       val3;
  logic [7:0]               crc3;

  // per-stage ready: a stage may load when empty or when it drains
  logic r1, r2, r3;
  assign r3 = !v3 || out_ready;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign in_ready = r1;

  // stage 1 logic: first crc byte and status masking
  logic [7:0]  crc1_next;
  logic [15:0] raw1_next;
  always_comb begin
    crc1_next = crc8_byte(8'h00, high_byte);
    if (kind == KindTemp) begin
      raw1_next = {high_byte, low_byte} & TempMask;
    end else begin
      raw1_next = {high_byte, low_byte} & HumiMask;
    end
  end

  // stage 2 logic: second crc byte and gain multiply
  logic [7:0]       crc2_next;
  logic [GainW-1:0] gain;
  logic [ProdW-1:0] prod2_next;
  always_comb begin
    crc2_next = crc8_byte(crc1, lo1);
    gain = (kind1 == KindTemp) ? TempGain : HumiGain;
    prod2_next = ProdW'(gain) * ProdW'(raw1);
  end

  // stage 3 logic: floor, offset, checksum compare
  logic               ok3_next;
  logic signed [15:0] scaled;
  logic signed [15:0] offset;
  logic signed [14:0] val3_next;
  always_comb begin
    ok3_next = (crc2 == chk2);
    offset = (kind2 == KindTemp) ? TempOffset : HumiOffset;
    scaled = $signed({1'b0, prod2[ProdW-1:16]}) - offset;
    val3_next = ok3_next ? scaled[14:0] : 15'sd0;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (r1) v1 <= in_valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && r1) begin
      kind1 <= kind;
      lo1   <= low_byte;
      chk1  <= check_byte;
      crc1  <= crc1_next;
      raw1  <= raw1_next;
    end
    if (v1 && r2) begin
      kind2 <= kind1;
      chk2  <= chk1;
      crc2  <= crc2_next;
      prod2 <= prod2_next;
    end
    if (v2 && r3) begin
      ok3  <= ok3_next;
      val3 <= val3_next;
      crc3 <= crc2;
    end
  end

  assign out_valid        = v3;
  assign check_ok         = ok3;
  assign value_hundredths = val3;
  assign computed_crc     = crc3;

endmodule

@@ design/htfcc_checker.sv @@
// port-level checks for the frame check and convert block, bound to its top level
`include "humidity_temp_frame_check_convert_macros.svh"

module htfcc_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic               check_ok,
  input logic signed [14:0] value_hundredths,
  input logic [7:0]         computed_crc
);

  // a stalled result transaction stays put
  `HTFCC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(value_hundredths) && $stable(computed_crc) && $stable(check_ok))

  // bad checksum reports zero
  `HTFCC_ASSERT_IMP(a_bad_zero, out_valid && !check_ok, value_hundredths == 15'sd0)

  // converted value stays within the temperature and humidity span
  `HTFCC_ASSERT_IMP(a_range, out_valid && check_ok, (value_hundredths >= -15'sd4685) && (value_hundredths <= 15'sd12885))

  // pipeline is empty after reset
  `HTFCC_ASSERT_RST(a_rst_empty, !out_valid)

endmodule

bind humidity_temp_frame_check_convert htfcc_checker u_htfcc_checker (
  .clk              (clk),
  .rst              (rst),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .check_ok         (check_ok),
  .value_hundredths (value_hundredths),
  .computed_crc     (computed_crc)
);
